// ===== src/itoa_pkg.sv =====
// Shared constants, types and helpers of the integer to ASCII converter.
package itoa_pkg;

  // Operand and text geometry
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAX_CHARS   = 33;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned CFG_IDX_W   = 1;

  // Character counts run 0..MAX_CHARS, buffer addresses 0..MAX_CHARS-1
  localparam int unsigned CNT_W    = $clog2(MAX_CHARS + 1);
  localparam int unsigned ADDR_W   = $clog2(MAX_CHARS);
  localparam int unsigned PADCMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Divider: DIV_STEPS quotient bits a cycle over a dividend padded to DIV_W bits
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DIV_W      = DIV_CYCLES * DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Queue between front and back; depth is a power of two so pointers wrap
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAD   = CFG_IDX_W'(1);

  // Configuration reset values and radix limits
  localparam logic [CFG_W-1:0] RADIX_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] PAD_RESET   = CFG_W'(7);
  localparam logic [CFG_W-1:0] RADIX_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] RADIX_MAX   = CFG_W'(36);
  localparam logic [CFG_W-1:0] DEC_DIGITS  = CFG_W'(10);

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7a;

  // One classified item waiting for conversion
  typedef struct packed {
    logic                   neg;
    logic                   text_on;
    logic [VALUE_WIDTH-1:0] mag;
  } itoa_item_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [CFG_W-1:0]       rem;
  } itoa_div_res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_PLAN,
    BK_PAD,
    BK_RD,
    BK_SEND,
    BK_NUL
  } back_state_e;

  // Map a digit value to its lower-case ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [CFG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_LOW_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

// ===== src/itoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/itoa_div.sv =====
// Iterative divider by the radix: quotient and remainder, several bits a cycle.
module itoa_div import itoa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [CFG_W-1:0]       radix_i,
  output itoa_div_res_t          res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_nx;
  logic [CFG_W-1:0]     rem_q;
  logic [CFG_W:0]       rem_nx;

  // Restoring division over DIV_STEPS dividend bits
  always_comb begin
    quo_nx = quo_q;
    rem_nx = {1'b0, rem_q};
    for (int s = 0; s < int'(DIV_STEPS); s++) begin
      rem_nx = {rem_nx[CFG_W-1:0], quo_nx[DIV_W-1]};
      quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
      if (rem_nx >= {1'b0, radix_i}) begin
        rem_nx    = rem_nx - {1'b0, radix_i};
        quo_nx[0] = 1'b1;
      end
    end
  end

  // Sequence the passes over the dividend
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold the partial quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= DIV_W'(dividend_i);
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx[CFG_W-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q[VALUE_WIDTH-1:0];
  assign res_o.rem  = rem_q;

endmodule

// ===== src/itoa_front.sv =====
// Input side: accept words, split sign and magnitude, check the radix.
module itoa_front import itoa_pkg::*; (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [CFG_W-1:0]              radix_i,
  input  logic                          full_i,
  output logic                          push_o,
  output itoa_item_t                    item_o
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] raw;

  // Stall while the queue has no free slot
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  // Magnitude of a two's complement word; the most negative value maps to 2^(W-1)
  assign raw            = $unsigned(value_i);
  assign neg            = raw[VALUE_WIDTH-1];
  assign item_o.neg     = neg;
  assign item_o.mag     = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
  assign item_o.text_on = (radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX);

endmodule

// ===== src/itoa_queue.sv =====
// Short queue of classified words between the input side and the sequencer.
module itoa_queue import itoa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  itoa_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output itoa_item_t item_o
);

  itoa_item_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;

  assign full_o  = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + (QPTR_W + 1)'(1);
      2'b01:   fill_d = fill_q - (QPTR_W + 1)'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== src/itoa_back.sv =====
// Conversion sequencer: digit generation, text buffer and character output.
module itoa_back import itoa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  itoa_item_t         item_i,
  output logic               pop_o,
  input  logic [CFG_W-1:0]   radix_i,
  input  logic [CFG_W-1:0]   pad_width_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAR_W-1:0]  character_o,
  output logic               last_o
);

  back_state_e            state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       pad_left_q, pad_left_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;
  logic                   load;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] dividend;
  itoa_div_res_t          div_res;

  logic                   ram_we;
  logic [CHAR_W-1:0]      ram_wdata;
  logic [CHAR_W-1:0]      ram_rdata;
  logic [CNT_W-1:0]       rd_idx;

  logic [PADCMP_W-1:0]    pad_ext;
  logic [CNT_W-1:0]       pad_lim;
  logic [CNT_W-1:0]       count_inc;
  logic                   more_room;
  logic                   out_free;
  logic                   more_digits;

  // Clamp padding to the longest text
  assign pad_ext = PADCMP_W'(pad_width_i);
  assign pad_lim = (pad_ext > PADCMP_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : CNT_W'(pad_ext);

  assign count_inc   = count_q + CNT_W'(1);
  assign more_room   = (count_inc < CNT_W'(MAX_CHARS));
  assign more_digits = (div_res.quot != '0) && more_room;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign rd_idx      = count_q - CNT_W'(1);

  itoa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .radix_i    (radix_i),
    .res_o      (div_res)
  );

  // Text held least significant character first
  itoa_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_CHARS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = item_i.text_on ? BK_DIV : BK_PLAN;
        end
      end
      BK_DIV: begin
        if (div_res.done) begin
          if (more_digits) begin
            state_d = BK_DIV;
          end else if (neg_q && more_room) begin
            state_d = BK_SIGN;
          end else begin
            state_d = BK_PLAN;
          end
        end
      end
      BK_SIGN: state_d = BK_PLAN;
      BK_PLAN: begin
        if ((count_q == '0) && (pad_lim == '0)) begin
          state_d = BK_NUL;
        end else if (pad_lim > count_q) begin
          state_d = BK_PAD;
        end else begin
          state_d = BK_RD;
        end
      end
      BK_PAD: begin
        if (out_free && (pad_left_q == CNT_W'(1))) begin
          state_d = (count_q == '0) ? BK_IDLE : BK_RD;
        end
      end
      BK_RD: state_d = BK_SEND;
      BK_SEND: begin
        if (out_free) begin
          state_d = (count_q == CNT_W'(1)) ? BK_IDLE : BK_RD;
        end
      end
      BK_NUL: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    pop_o      = 1'b0;
    div_start  = 1'b0;
    dividend   = item_i.mag;
    ram_we     = 1'b0;
    ram_wdata  = digit_char(div_res.rem);
    count_d    = count_q;
    pad_left_d = pad_left_q;
    neg_d      = neg_q;
    load       = 1'b0;
    char_d     = char_q;
    last_d     = last_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o     = 1'b1;
          count_d   = '0;
          neg_d     = item_i.neg;
          div_start = item_i.text_on;
        end
      end
      BK_DIV: begin
        if (div_res.done) begin
          ram_we  = 1'b1;
          count_d = count_inc;
          if (more_digits) begin
            div_start = 1'b1;
            dividend  = div_res.quot;
          end
        end
      end
      BK_SIGN: begin
        ram_we    = 1'b1;
        ram_wdata = CH_MINUS;
        count_d   = count_inc;
      end
      BK_PLAN: begin
        pad_left_d = (pad_lim > count_q) ? (pad_lim - count_q) : '0;
      end
      BK_PAD: begin
        if (out_free) begin
          load       = 1'b1;
          char_d     = CH_SPACE;
          last_d     = (pad_left_q == CNT_W'(1)) && (count_q == '0);
          pad_left_d = pad_left_q - CNT_W'(1);
        end
      end
      BK_SEND: begin
        if (out_free) begin
          load    = 1'b1;
          char_d  = ram_rdata;
          last_d  = (count_q == CNT_W'(1));
          count_d = rd_idx;
        end
      end
      BK_NUL: begin
        if (out_free) begin
          load   = 1'b1;
          char_d = CH_NUL;
          last_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: load a character, drop it once taken
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      pad_left_q  <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pad_left_q  <= pad_left_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== src/integer_to_ascii_radix.sv =====
// Top level of the signed integer to right-justified ASCII text converter.
//
// Each input word is a signed 32-bit integer; the block sends its text in the
// configured radix (2 to 36) one character per output word, leading spaces up to
// pad_width (at most 33), then a minus sign for negative values, then digits
// most significant first in lower case, with last set on the final character.
// A radix outside 2..36 gives padding only, and a single NUL with last set if
// pad_width is zero. Each digit comes from the shared divider (8 quotient bits
// a cycle over the 32-bit magnitude) and is then stored in the text buffer, the
// sign after it. Every digit or sign character then leaves through the single
// read port of the text buffer. The word is popped from the queue as the
// divider starts, and the padding is planned once the text is stored. A two-word
// queue lets the input side take further words while a conversion runs, and a
// character held in the output register blocks the sequencer only while the
// output is stalled.
module integer_to_ascii_radix import itoa_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CHAR_W-1:0]             character_o,
  output logic                          last_o
);

  logic [CFG_W-1:0] radix_q, radix_d;
  logic [CFG_W-1:0] pad_q, pad_d;

  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  itoa_item_t       front_item;
  itoa_item_t       queue_item;

  // Configuration registers
  always_comb begin
    radix_d = radix_q;
    pad_d   = pad_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIX: radix_d = cfg_data_i;
        CFG_PAD:   pad_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      pad_q   <= PAD_RESET;
    end else begin
      radix_q <= radix_d;
      pad_q   <= pad_d;
    end
  end

  itoa_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .radix_i    (radix_q),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  itoa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  itoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (queue_item),
    .pop_o       (pop),
    .radix_i     (radix_q),
    .pad_width_i (pad_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// ===== src/itoa_checker.sv =====
// Port-level checks for the integer to ASCII converter, bound to the top level.
module itoa_checker import itoa_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [VALUE_WIDTH-1:0] value_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [CHAR_W-1:0]             character_o,
  input logic                          last_o
);

  logic is_digit;
  logic out_take;

  assign is_digit = ((character_o >= CH_ZERO) && (character_o <= CH_NINE)) ||
                    ((character_o >= CH_LOW_A) && (character_o <= CH_LOW_Z));
  assign out_take = out_valid_o && !out_stall_i;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(value_i))
    else $error("input word changed while stalled");

  // Only text characters appear, and NUL only as a final character
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_digit || (character_o == CH_SPACE) || (character_o == CH_MINUS) ||
                    ((character_o == CH_NUL) && last_o))
    else $error("illegal character sent");

  // Within one conversion, a digit is followed by digits only
  a_digit_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && is_digit && !last_o |=> !out_valid_o || is_digit)
    else $error("non-digit after a digit within one conversion");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);

// ===== tb/integer_to_ascii_radix_test.sv =====
// Self-checking testbench for the signed integer to ASCII radix converter.
module integer_to_ascii_radix_test;
  import itoa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned SETTLE      = 40;

  // Digit glyphs, value 0 in the top byte
  localparam logic [8*36-1:0] DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_word_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx_i = '0;
  logic [CFG_W-1:0]              cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [CHAR_W-1:0]             character_o;
  logic                          last_o;

  // Predictor copy of the configuration
  logic [CFG_W-1:0] cur_radix = RADIX_RESET;
  logic [CFG_W-1:0] cur_pad   = PAD_RESET;

  char_word_t expected_chars[$];

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned values_sent   = 0;
  int unsigned chars_checked = 0;
  int unsigned lines_checked = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_hold_left  = 0;

  integer_to_ascii_radix DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL integer_to_ascii_radix");
      $finish;
    end
  end

  // Receiver back-pressure: a long hold-off first, else random stalls
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Work out the text of one value under the current settings
  task automatic predict_text(input logic [VALUE_WIDTH-1:0] raw);
    logic [VALUE_WIDTH-1:0] quot;
    logic [CHAR_W-1:0]      text[$];
    int unsigned            digit;
    int unsigned            pad;
    char_word_t             w;
    quot = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
    if (cur_radix >= RADIX_MIN && cur_radix <= RADIX_MAX) begin
      // Collect digits least significant first
      do begin
        digit = quot % cur_radix;
        text.push_front(DIGIT_SET[8*(35-digit) +: 8]);
        quot = quot / cur_radix;
      end while (quot != 0 && text.size() < MAX_CHARS);
      if (raw[VALUE_WIDTH-1] && text.size() < MAX_CHARS) begin
        text.push_front(CH_MINUS);
      end
    end
    pad = (cur_pad > MAX_CHARS) ? MAX_CHARS : cur_pad;
    if (pad == 0 && text.size() == 0) begin
      w.ch   = CH_NUL;
      w.last = 1'b1;
      expected_chars.push_back(w);
    end else begin
      while (text.size() < pad) begin
        text.push_front(CH_SPACE);
      end
      foreach (text[i]) begin
        w.ch   = text[i];
        w.last = (i == text.size() - 1);
        expected_chars.push_back(w);
      end
    end
    lines_checked++;
  endtask

  // Compare each accepted character with the oldest expectation
  always @(posedge clk_i) begin : check_chars
    char_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", character_o, last_o));
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (character_o !== want.ch) begin
          report_mismatch($sformatf("character %h, want %h", character_o, want.ch));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %b, want %b (char %h)", last_o, want.last, want.ch));
        end
      end
    end
  end

  // Offer one word and hold it until accepted; called and returns at a falling edge
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_text(v);
    values_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected character has come
  task automatic drain;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_chars.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Register write while idle; called and returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RADIX) begin
      cur_radix = data;
    end else begin
      cur_pad = data;
    end
    @(negedge clk_i);
  endtask

  task automatic set_format(input logic [CFG_W-1:0] radix, input logic [CFG_W-1:0] pad);
    drain();
    write_reg(CFG_RADIX, radix);
    write_reg(CFG_PAD, pad);
  endtask

  function automatic logic [CFG_W-1:0] pick_radix();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 2) begin
      return (sel == 0) ? CFG_W'(10) : CFG_W'(16);
    end else if (sel < 4) begin
      // Invalid bases: below two or above thirty-six
      return ($urandom_range(3) == 0) ? CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(37, 63));
    end
    return CFG_W'($urandom_range(2, 36));
  endfunction

  function automatic logic [CFG_W-1:0] pick_pad();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 14) begin
      return CFG_W'($urandom_range(12));
    end else if (sel < 17) begin
      return CFG_W'($urandom_range(13, MAX_CHARS));
    end
    return CFG_W'($urandom_range(MAX_CHARS + 1, 63));
  endfunction

  // Values biased to extremes, small numbers and radix powers
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    logic [VALUE_WIDTH-1:0] v;
    longint unsigned        p;
    int unsigned            k;
    case ($urandom_range(9))
      4: v = VALUE_WIDTH'($signed($urandom_range(80)) - 40);
      5: begin
        case ($urandom_range(4))
          0: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
          1: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
          2: v = '0;
          3: v = '1;
          default: v = VALUE_WIDTH'(1);
        endcase
      end
      6: begin
        p = 1;
        k = $urandom_range(1, 31);
        if (cur_radix >= RADIX_MIN) begin
          while (k > 0 && p * cur_radix < 64'h8000_0000) begin
            p = p * cur_radix;
            k--;
          end
        end
        v = VALUE_WIDTH'(p) + VALUE_WIDTH'($signed($urandom_range(2)) - 1);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      7: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_reset_format;
    send_value(32'sd0);
    send_value(-32'sd1);
    send_value(32'sd1234567);
    send_value({1'b1, {(VALUE_WIDTH-1){1'b0}}});
    send_value({1'b0, {(VALUE_WIDTH-1){1'b1}}});
  endtask

  task automatic test_directed;
    // Binary without padding: longest text, most negative value
    set_format(CFG_W'(2), CFG_W'(0));
    send_value({1'b1, {(VALUE_WIDTH-1){1'b0}}});
    send_value({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    send_value(32'sd0);
    send_value(-32'sd1);
    // Base thirty-six with full padding
    set_format(RADIX_MAX, CFG_W'(MAX_CHARS));
    send_value({1'b1, {(VALUE_WIDTH-1){1'b0}}});
    send_value({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    send_value(32'sd35);
    // Padding above the text limit is clipped
    set_format(CFG_W'(16), CFG_W'(63));
    send_value(-32'sd255);
    send_value(32'sh7fff_ffff);
    // Invalid base with no padding sends a lone NUL
    set_format(CFG_W'(0), CFG_W'(0));
    send_value(32'sd5);
    set_format(CFG_W'(63), CFG_W'(0));
    send_value(-32'sd1);
    // Invalid base with padding sends spaces only
    set_format(CFG_W'(1), CFG_W'(5));
    send_value(32'sd7);
    set_format(CFG_W'(37), CFG_W'(1));
    send_value(-32'sd9);
    // Text exactly as long as the padding, and one character shorter
    set_format(CFG_W'(10), CFG_W'(11));
    send_value({1'b1, {(VALUE_WIDTH-1){1'b0}}});
    send_value(32'sd1000000000);
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input int unsigned segments, input int unsigned per_seg);
    drain();
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (segments) begin
      set_format(pick_radix(), pick_pad());
      repeat (per_seg) send_value(pick_value());
    end
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure;
    set_format(CFG_W'(2), CFG_W'(MAX_CHARS));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    rx_hold_left = 900;
    @(negedge clk_i);
    repeat (12) send_value(pick_value());
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_format();
    test_directed();
    test_random_phase(0, 0, 4, 22);
    test_random_phase(63, 0, 4, 22);
    test_random_phase(0, 63, 4, 22);
    test_random_phase(16, 16, 4, 22);
    test_backpressure();

    drain();
    repeat (2 * SETTLE) @(negedge clk_i);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
    end
    $display("Converted %0d values (%0d conversions predicted), %0d characters compared",
             values_sent, lines_checked, chars_checked);
    $display("Bases 0..63, padding 0..63, idle and stall mixes, long receiver hold-off");
    if (error_count == 0) begin
      $display("PASS integer_to_ascii_radix");
    end else begin
      $display("FAIL integer_to_ascii_radix");
    end
    $finish;
  end

endmodule
